@@ src/swap_shuffle_permutation_engine_assert.svh @@
// Assertion macros shared by the swap shuffle permutation engine modules
`ifndef SWAP_SHUFFLE_PERMUTATION_ENGINE_ASSERT_SVH
`define SWAP_SHUFFLE_PERMUTATION_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SSPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SSPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sspe_pkg.sv @@
// Types and constants shared by the swap shuffle permutation engine
package sspe_pkg;

  // Field widths
  localparam int CW = 11;  // entries, step count, size register
  localparam int IW = 10;  // read index and swap partner ports
  localparam int RW = 31;  // random word

  localparam logic [CW-1:0] SIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_SHUFFLE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_DIV,
    ST_SWAP_RD,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_READ,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic fill_wr;    // write one identity entry
    logic div_start;  // start remainder unit
    logic swap_rd;    // read both swap entries
    logic wr_a;       // write entry at step
    logic wr_b;       // write entry at partner, advance step
    logic rd_entry;   // read entry for a read item
    logic result_ld;  // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  fill_last;
    logic  shuffle_ok;
    logic  rem_done;
    logic  out_free;
  } sts_t;

endpackage

@@ src/sspe_rem.sv @@
// Bit-serial remainder unit: 31-bit dividend modulo 11-bit divisor
module sspe_rem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [sspe_pkg::RW-1:0] dividend,
  input  logic [sspe_pkg::CW-1:0] divisor,
  output logic [sspe_pkg::CW-1:0] rem,
  output logic                   done
);

  localparam int CNTW = $clog2(sspe_pkg::RW + 1);

  logic [sspe_pkg::RW-1:0] dvd_r, dvd_nxt;
  logic [sspe_pkg::CW-1:0] rem_r, rem_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [sspe_pkg::CW:0]   trial;
  logic [sspe_pkg::CW:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, dvd_r[sspe_pkg::RW-1]};
    diff     = trial - {1'b0, divisor};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(sspe_pkg::RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[sspe_pkg::RW-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[sspe_pkg::CW-1:0]
                                           : trial[sspe_pkg::CW-1:0];
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control flags under reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

@@ src/sspe_dp.sv @@
// Datapath: permutation memory, step state, remainder unit and output register
`include "swap_shuffle_permutation_engine_assert.svh"

module sspe_dp #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sspe_pkg::cmd_t          cmd,
  output sspe_pkg::sts_t          sts,
  input  logic [1:0]              in_mode,
  input  logic [sspe_pkg::RW-1:0] in_random_word,
  input  logic [sspe_pkg::IW-1:0] in_read_index,
  input  logic                    cfg_wr_en,
  input  logic [sspe_pkg::CW-1:0] cfg_wr_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [sspe_pkg::CW-1:0] out_entry_value,
  output logic [sspe_pkg::IW-1:0] out_swap_partner,
  output logic [sspe_pkg::CW-1:0] out_step_index,
  output logic                    out_done_res
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = sspe_pkg::CW;

  // Item and state registers
  sspe_pkg::mode_t          mode_r;
  logic [sspe_pkg::RW-1:0]  rnd_r;
  logic [sspe_pkg::IW-1:0]  ridx_r;
  logic [CW-1:0]            size_r;
  logic [CW-1:0]            step_r;
  logic                     started_r;
  logic [CW-1:0]            fill_ptr_r;
  logic [sspe_pkg::IW-1:0]  partner_r;
  logic [CW-1:0]            ra_r, rb_r;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [CW-1:0]            entry_r;
  logic [sspe_pkg::IW-1:0]  out_partner_r;
  logic [CW-1:0]            out_step_r;
  logic                     out_done_r;

  logic [CW-1:0]            eff_size;
  logic                     read_ok;
  logic                     done_now;
  logic [CW-1:0]            rem_q;
  logic                     rem_done;

  logic [CW-1:0] mem [MAX_ENTRIES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr0;
  logic [AW-1:0] mem_raddr1;

  // Clamp the size register to 1..MAX_ENTRIES
  always_comb begin
    if (size_r == '0) begin
      eff_size = CW'(1);
    end else if (32'(size_r) > MAX_ENTRIES) begin
      eff_size = CW'(MAX_ENTRIES);
    end else begin
      eff_size = size_r;
    end
  end

  assign read_ok  = started_r && (CW'(ridx_r) < eff_size);
  assign done_now = started_r && (step_r >= eff_size);

  assign sts.mode       = mode_r;
  assign sts.fill_last  = (fill_ptr_r == eff_size - CW'(1));
  assign sts.shuffle_ok = started_r && (step_r < eff_size);
  assign sts.rem_done   = rem_done;
  assign sts.out_free   = !out_valid_r || !out_stall;

  sspe_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rnd_r),
    .divisor  (step_r),
    .rem      (rem_q),
    .done     (rem_done)
  );

  // Capture the item fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= sspe_pkg::mode_t'(in_mode);
      rnd_r  <= in_random_word;
      ridx_r <= in_read_index;
    end
  end

  // Size, step and started state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= sspe_pkg::SIZE_RST;
      step_r    <= CW'(1);
      started_r <= 1'b0;
    end else if (cfg_wr_en) begin
      size_r    <= cfg_wr_data;
      started_r <= 1'b0;
    end else if (cmd.fill_wr && sts.fill_last) begin
      step_r    <= CW'(1);
      started_r <= 1'b1;
    end else if (cmd.wr_b) begin
      step_r <= step_r + CW'(1);
    end
  end

  // Fill pointer and reported partner
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fill_ptr_r <= '0;
      partner_r  <= '0;
    end else begin
      if (cmd.fill_wr) begin
        fill_ptr_r <= fill_ptr_r + CW'(1);
      end
      if (cmd.wr_b) begin
        partner_r <= rem_q[sspe_pkg::IW-1:0];
      end
    end
  end

  // Memory port selection
  always_comb begin
    mem_we     = cmd.fill_wr || cmd.wr_a || cmd.wr_b;
    mem_waddr  = AW'(rem_q);
    mem_wdata  = ra_r;
    if (cmd.fill_wr) begin
      mem_waddr = AW'(fill_ptr_r);
      mem_wdata = fill_ptr_r + CW'(1);
    end else if (cmd.wr_a) begin
      mem_waddr = AW'(step_r);
      mem_wdata = rb_r;
    end
    mem_raddr0 = cmd.rd_entry ? AW'(ridx_r) : AW'(step_r);
    mem_raddr1 = AW'(rem_q);
  end

  // Permutation memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.swap_rd || cmd.rd_entry) begin
      ra_r <= mem[mem_raddr0];
    end
    if (cmd.swap_rd) begin
      rb_r <= mem[mem_raddr1];
    end
  end

  // Output register: hold while stalled, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.result_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.result_ld) begin
      entry_r       <= (mode_r == sspe_pkg::MODE_READ && read_ok) ? ra_r : '0;
      out_partner_r <= partner_r;
      out_step_r    <= step_r;
      out_done_r    <= done_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_value  = entry_r;
  assign out_swap_partner = out_partner_r;
  assign out_step_index   = out_step_r;
  assign out_done_res     = out_done_r;

  `SSPE_ASSERT_IMP(a_partner_below_step, clk, rst_n, cmd.wr_b, rem_q < step_r, "partner not below step")
  `SSPE_ASSERT_NXT(a_fill_starts, clk, rst_n, cmd.fill_wr && sts.fill_last && !cfg_wr_en, started_r && step_r == CW'(1), "restart did not arm the shuffle")
  `SSPE_ASSERT_IMP(a_load_free, clk, rst_n, cmd.result_ld, !out_valid_r || !out_stall, "result loaded over a waiting item")

endmodule

@@ src/sspe_ctrl.sv @@
// Controller: sequences restart fill, shuffle swap and entry read per item
`include "swap_shuffle_permutation_engine_assert.svh"

module sspe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sspe_pkg::sts_t sts,
  output sspe_pkg::cmd_t cmd
);

  sspe_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sspe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sspe_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sspe_pkg::ST_DECODE;
      end
      sspe_pkg::ST_DECODE: begin
        case (sts.mode)
          sspe_pkg::MODE_RESTART: state_nxt = sspe_pkg::ST_FILL;
          sspe_pkg::MODE_SHUFFLE: begin
            state_nxt = sts.shuffle_ok ? sspe_pkg::ST_DIV : sspe_pkg::ST_RESULT;
          end
          sspe_pkg::MODE_READ:    state_nxt = sspe_pkg::ST_READ;
          default:                state_nxt = sspe_pkg::ST_RESULT;
        endcase
      end
      sspe_pkg::ST_FILL: begin
        if (sts.fill_last) state_nxt = sspe_pkg::ST_RESULT;
      end
      sspe_pkg::ST_DIV: begin
        if (sts.rem_done) state_nxt = sspe_pkg::ST_SWAP_RD;
      end
      sspe_pkg::ST_SWAP_RD: state_nxt = sspe_pkg::ST_SWAP_WA;
      sspe_pkg::ST_SWAP_WA: state_nxt = sspe_pkg::ST_SWAP_WB;
      sspe_pkg::ST_SWAP_WB: state_nxt = sspe_pkg::ST_RESULT;
      sspe_pkg::ST_READ:    state_nxt = sspe_pkg::ST_RESULT;
      sspe_pkg::ST_RESULT: begin
        if (sts.out_free) state_nxt = sspe_pkg::ST_IDLE;
      end
      default: state_nxt = sspe_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != sspe_pkg::ST_IDLE);
    case (state_r)
      sspe_pkg::ST_IDLE:    cmd.load = in_valid;
      sspe_pkg::ST_DECODE: begin
        cmd.div_start = (sts.mode == sspe_pkg::MODE_SHUFFLE) && sts.shuffle_ok;
      end
      sspe_pkg::ST_FILL:    cmd.fill_wr   = 1'b1;
      sspe_pkg::ST_SWAP_RD: cmd.swap_rd   = 1'b1;
      sspe_pkg::ST_SWAP_WA: cmd.wr_a      = 1'b1;
      sspe_pkg::ST_SWAP_WB: cmd.wr_b      = 1'b1;
      sspe_pkg::ST_READ:    cmd.rd_entry  = 1'b1;
      sspe_pkg::ST_RESULT:  cmd.result_ld = sts.out_free;
      default:              cmd           = '0;
    endcase
  end

  `SSPE_ASSERT_NXT(a_swap_pair, clk, rst_n, cmd.wr_a, cmd.wr_b, "swap write pair broken")
  `SSPE_ASSERT_IMP(a_rem_in_div, clk, rst_n, sts.rem_done, state_r == sspe_pkg::ST_DIV, "remainder finished outside divide wait")
  `SSPE_ASSERT_NXT(a_result_idle, clk, rst_n, cmd.result_ld, state_r == sspe_pkg::ST_IDLE && !in_stall, "not idle after result")

endmodule

@@ src/swap_shuffle_permutation_engine.sv @@
// Top level of the swap shuffle permutation engine (cyclic in-place shuffle)
//
// Input channel in_*: one item per handshake, in_mode selects restart (fill
// entries with 1..size, step back to 1), shuffle step (swap entry step with
// entry random_word mod step, then advance) or read of one entry. Every item
// gives exactly one result on out_*: entry value, swap partner, step after
// the item and the done flag. cfg_wr_en/cfg_wr_data write the size register;
// the user must write it only while the block is idle, which the block does
// not enforce. A write clears the started flag. One item is in work at a
// time; the next is taken in the cycle after the previous result is loaded
// into the output register. A shuffle step waits on the bit-serial remainder
// unit, then does a read-swap-write on the memory; a restart writes one
// identity entry per cycle on the single write port.
// Reset returns to idle with size 1024, step 1 and nothing started; memory
// contents are undefined until a restart fills them. While the receiver
// stalls, the result holds in the output register; a finished following
// item waits in its last state until the register is free.
module swap_shuffle_permutation_engine #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_mode,
  input  logic [sspe_pkg::RW-1:0] in_random_word,
  input  logic [sspe_pkg::IW-1:0] in_read_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [sspe_pkg::CW-1:0] out_entry_value,
  output logic [sspe_pkg::IW-1:0] out_swap_partner,
  output logic [sspe_pkg::CW-1:0] out_step_index,
  output logic                    out_done_res,
  input  logic                    cfg_wr_en,
  input  logic [sspe_pkg::CW-1:0] cfg_wr_data
);

  sspe_pkg::cmd_t cmd;
  sspe_pkg::sts_t sts;

  // Sequence control
  sspe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  sspe_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_random_word   (in_random_word),
    .in_read_index    (in_read_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entry_value  (out_entry_value),
    .out_swap_partner (out_swap_partner),
    .out_step_index   (out_step_index),
    .out_done_res     (out_done_res)
  );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the swap shuffle permutation engine
module testbench;

  localparam int CW            = sspe_pkg::CW;
  localparam int IW            = sspe_pkg::IW;
  localparam int RW            = sspe_pkg::RW;
  localparam int MAX_ENTRIES   = 1024;
  localparam int ITEM_TARGET   = 1250;
  localparam int HOLDOFF_AT    = 300;
  localparam int HOLDOFF_LEN   = 400;
  localparam int QUIET_LIMIT   = 8000;
  localparam int SETTLE_CYCLES = 40;

  // One result of the engine, field by field
  typedef struct packed {
    logic [CW-1:0] entry_value;
    logic [IW-1:0] swap_partner;
    logic [CW-1:0] step_index;
    logic          done_res;
  } shuffle_outcome_t;

  // Mirror of the permutation store, step and size; queues the outcome of each item
  class perm_mirror;
    logic [CW-1:0]    perm [];
    int unsigned      max_entries;
    int unsigned      size_reg;
    int unsigned      step_count;
    bit               started;
    shuffle_outcome_t awaited [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      swaps;
    int unsigned      deepest_step;

    function new(int unsigned max_entries_i);
      max_entries  = max_entries_i;
      perm         = new[max_entries];
      foreach (perm[i]) perm[i] = '0;
      size_reg     = 32'(sspe_pkg::SIZE_RST);
      step_count   = 1;
      started      = 1'b0;
      mismatches   = 0;
      checked      = 0;
      swaps        = 0;
      deepest_step = 1;
    endfunction

    // Clamp the size register to the entries that exist
    function int unsigned live_size();
      int unsigned s;
      s = size_reg;
      if (s < 1) s = 1;
      if (s > max_entries) s = max_entries;
      return s;
    endfunction

    // A size write drops the started flag
    function void write_size(int unsigned value);
      size_reg = value & 32'h7FF;
      started  = 1'b0;
    endfunction

    // Apply one accepted item and queue the outcome it must give
    function void note_item(sspe_pkg::mode_t m, logic [RW-1:0] rnd, logic [IW-1:0] ridx);
      int unsigned      s;
      int unsigned      a;
      int unsigned      b;
      int unsigned      w;
      logic [CW-1:0]    t;
      shuffle_outcome_t o;
      s = live_size();
      w = 32'(rnd);
      o = '0;
      case (m)
        sspe_pkg::MODE_RESTART: begin
          for (int i = 0; i < s; i++) perm[i] = CW'(i + 1);
          step_count = 1;
          started    = 1'b1;
        end
        sspe_pkg::MODE_SHUFFLE: begin
          if (started && step_count < s && step_count >= 1) begin
            a          = step_count;
            b          = w % a;
            t          = perm[a];
            perm[a]    = perm[b];
            perm[b]    = t;
            o.swap_partner = IW'(b);
            step_count = a + 1;
            swaps++;
            if (step_count > deepest_step) deepest_step = step_count;
          end
        end
        sspe_pkg::MODE_READ: begin
          if (started && ridx < s) o.entry_value = perm[ridx];
        end
        default: ;
      endcase
      o.step_index = CW'(step_count);
      o.done_res   = started && step_count >= s;
      awaited.push_back(o);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= 100)
        $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want, checked);
    endtask

    // Compare one accepted result with the oldest queued outcome
    task check_report(shuffle_outcome_t got);
      shuffle_outcome_t want;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing awaited", 0, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.entry_value !== want.entry_value)
        report_mismatch("entry_value", 32'(got.entry_value), 32'(want.entry_value));
      if (got.swap_partner !== want.swap_partner)
        report_mismatch("swap_partner", 32'(got.swap_partner), 32'(want.swap_partner));
      if (got.step_index !== want.step_index)
        report_mismatch("step_index", 32'(got.step_index), 32'(want.step_index));
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
    endtask
  endclass

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_stall;
  logic [1:0]    in_mode        = '0;
  logic [RW-1:0] in_random_word = '0;
  logic [IW-1:0] in_read_index  = '0;
  logic          out_valid;
  logic          out_stall      = 1'b0;
  logic [CW-1:0] out_entry_value;
  logic [IW-1:0] out_swap_partner;
  logic [CW-1:0] out_step_index;
  logic          out_done_res;
  logic          cfg_wr_en      = 1'b0;
  logic [CW-1:0] cfg_wr_data    = '0;

  perm_mirror       sb = new(MAX_ENTRIES);
  shuffle_outcome_t seen;
  int               items_sent    = 0;
  int               send_idle     = 6;
  int               recv_idle     = 62;
  int               phases        = 0;
  int               restarts      = 0;
  int               reads         = 0;
  int               quiet_cycles  = 0;
  int               held_cycles   = 0;
  int               holdoff_left  = 0;
  logic             holdoff_req   = 1'b0;
  bit               holdoff_taken = 1'b0;

  swap_shuffle_permutation_engine #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_random_word   (in_random_word),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entry_value  (out_entry_value),
    .out_swap_partner (out_swap_partner),
    .out_step_index   (out_step_index),
    .out_done_res     (out_done_res),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Receive results, check them and drive the stall, with one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.entry_value  = out_entry_value;
        seen.swap_partner = out_swap_partner;
        seen.step_index   = out_step_index;
        seen.done_res     = out_done_res;
        sb.check_report(seen);
      end
      if (holdoff_req && !holdoff_taken) begin
        holdoff_left  = HOLDOFF_LEN;
        holdoff_taken = 1'b1;
      end
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watch for a hung handshake
  always @(posedge clk) begin
    if (in_valid && in_stall) held_cycles++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [RW-1:0] draw_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return RW'($urandom());
    endcase
  endfunction

  // Offer one item, idling first at the current rate, and hold it until taken
  task automatic send_item(input sspe_pkg::mode_t m, input logic [RW-1:0] rnd,
                           input int unsigned ridx);
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle = 6;
      recv_idle = 62;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle = 62;
      recv_idle = 6;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      in_mode  <= 2'($urandom_range(3));
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_random_word <= rnd;
    in_read_index  <= IW'(ridx);
    do @(posedge clk); while (in_stall);
    sb.note_item(m, rnd, IW'(ridx));
    items_sent++;
    if (m == sspe_pkg::MODE_RESTART) restarts++;
    if (m == sspe_pkg::MODE_READ) reads++;
    if (items_sent == HOLDOFF_AT) holdoff_req <= 1'b1;
  endtask

  // Stop offering and wait for every queued outcome to arrive
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the size register while the engine is idle
  task automatic write_size(input int unsigned value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CW'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_size(value);
    phases++;
  endtask

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return 1;
    if (r < 14) return 2;
    if (r < 17) return 1024;
    if (r < 19) return $urandom_range(1025, 2047);
    if (r < 24) return $urandom_range(65, 1023);
    return $urandom_range(3, 48);
  endfunction

  // One size setting: some noise, a restart, a shuffle run and read-back
  task automatic run_phase(input int unsigned size_val);
    int unsigned s;
    int unsigned goal;
    int unsigned done_swaps;
    bit          broken;
    write_size(size_val);
    s = sb.live_size();
    broken = ($urandom_range(4) == 0);
    // items that arrive while nothing is started
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        send_item(sspe_pkg::mode_t'($urandom_range(3)), draw_word(), $urandom_range(1023));
    send_item(sspe_pkg::MODE_RESTART, draw_word(), $urandom_range(1023));
    goal = (s <= 64) ? s - 1 + $urandom_range(0, 3) : $urandom_range(8, 60);
    done_swaps = 0;
    while (done_swaps < goal) begin
      case ($urandom_range(19))
        0: begin
          if (broken) send_item(sspe_pkg::MODE_RESTART, draw_word(), $urandom_range(1023));
          else send_item(sspe_pkg::MODE_NONE, draw_word(), $urandom_range(1023));
        end
        1: send_item(sspe_pkg::MODE_NONE, draw_word(), $urandom_range(1023));
        2, 3, 4: send_item(sspe_pkg::MODE_READ, draw_word(), $urandom_range(s - 1));
        default: begin
          send_item(sspe_pkg::MODE_SHUFFLE, draw_word(), $urandom_range(1023));
          done_swaps++;
        end
      endcase
    end
    // read back the permutation
    if (s <= 32) begin
      for (int i = 0; i < s; i++) send_item(sspe_pkg::MODE_READ, draw_word(), i);
    end else begin
      repeat (12) send_item(sspe_pkg::MODE_READ, draw_word(), $urandom_range(s - 1));
    end
    if (s < MAX_ENTRIES)
      send_item(sspe_pkg::MODE_READ, draw_word(), $urandom_range(s, 1023));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing started yet at reset size
    send_item(sspe_pkg::MODE_READ, '1, 0);
    send_item(sspe_pkg::MODE_SHUFFLE, '1, 1023);
    send_item(sspe_pkg::MODE_NONE, '1, 1023);
    // Size zero acts as one: done straight after restart
    write_size(0);
    send_item(sspe_pkg::MODE_RESTART, '0, 0);
    send_item(sspe_pkg::MODE_SHUFFLE, '1, 0);
    send_item(sspe_pkg::MODE_READ, '0, 0);
    send_item(sspe_pkg::MODE_READ, '0, 1);
    // Short full shuffle, shuffle when done, out-of-range read, unused mode
    write_size(4);
    send_item(sspe_pkg::MODE_RESTART, '1, 1023);
    send_item(sspe_pkg::MODE_SHUFFLE, '0, 0);
    send_item(sspe_pkg::MODE_SHUFFLE, '1, 0);
    send_item(sspe_pkg::MODE_SHUFFLE, RW'($urandom()), 0);
    send_item(sspe_pkg::MODE_SHUFFLE, RW'($urandom()), 0);
    for (int i = 0; i < 5; i++) send_item(sspe_pkg::MODE_READ, '0, i);
    send_item(sspe_pkg::MODE_NONE, '0, 0);
    // Rewriting the size drops the started flag
    write_size(4);
    send_item(sspe_pkg::MODE_READ, '0, 0);
    send_item(sspe_pkg::MODE_SHUFFLE, '1, 0);
    // Size above the store clamps to the full store
    write_size(2047);
    send_item(sspe_pkg::MODE_RESTART, '0, 0);
    send_item(sspe_pkg::MODE_SHUFFLE, '1, 0);
    send_item(sspe_pkg::MODE_READ, '0, 1023);
    send_item(sspe_pkg::MODE_READ, '0, 1);

    // Random size settings until the item budget is spent
    while (items_sent < ITEM_TARGET) run_phase(pick_size());
    write_size(1024);
    run_phase(1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d items over %0d size settings: %0d restarts, %0d swaps, %0d reads",
             items_sent, phases, restarts, sb.swaps, reads);
    $display("checked %0d results; deepest step %0d; input held off for %0d cycles",
             sb.checked, sb.deepest_step, held_cycles);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
